@@ rtl/dasd_pkg.sv @@
// ----------------------------------------------------------------------------
// dasd_pkg
// Types, constants and calendar helpers for the date add/subtract unit.
// ----------------------------------------------------------------------------
package dasd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int INCNT_W = 16;
    localparam int QUO_W   = 7;

    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [INCNT_W-1:0] incnt_t;
    typedef logic [QUO_W-1:0]   quo_t;

    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_APR = 4'd4;
    localparam month_t MONTH_JUN = 4'd6;
    localparam month_t MONTH_SEP = 4'd9;
    localparam month_t MONTH_NOV = 4'd11;
    localparam month_t MONTH_DEC = 4'd12;

    localparam year_t YEAR_MIN     = 14'd1;
    localparam year_t YEAR_MAX     = 14'd9999;
    localparam year_t YEAR_CENTURY = 14'd100;
    localparam year_t YEAR_REM_TOP = 14'd99;

    localparam day_t DAYS_31 = 5'd31;
    localparam day_t DAYS_30 = 5'd30;
    localparam day_t DAYS_29 = 5'd29;
    localparam day_t DAYS_28 = 5'd28;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_step;
        logic check;
        logic walk_step;
        logic out_load;
    } dasd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic invalid;
        logic walk_done;
        logic step_err;
    } dasd_status_t;

    function automatic day_t month_length(input month_t m, input logic leap);
        day_t len;
        len = DAYS_31;
        if (m == MONTH_FEB)
        begin
            len = leap ? DAYS_29 : DAYS_28;
        end
        else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
        begin
            len = DAYS_30;
        end
        return len;
    endfunction

endpackage

@@ rtl/dasd_if.sv @@
// ----------------------------------------------------------------------------
// dasd_in_if / dasd_out_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface dasd_in_if;
    logic              valid;
    logic              ready;
    logic              operation;
    dasd_pkg::day_t    start_day;
    dasd_pkg::month_t  start_month;
    dasd_pkg::year_t   start_year;
    dasd_pkg::incnt_t  day_count;

    modport source (output valid, operation, start_day, start_month, start_year, day_count,
                    input ready);
    modport sink   (input valid, operation, start_day, start_month, start_year, day_count,
                    output ready);
endinterface

interface dasd_out_if;
    logic              valid;
    logic              ready;
    dasd_pkg::day_t    result_day;
    dasd_pkg::month_t  result_month;
    dasd_pkg::year_t   result_year;
    logic              range_error;

    modport source (output valid, result_day, result_month, result_year, range_error,
                    input ready);
    modport sink   (input valid, result_day, result_month, result_year, range_error,
                    output ready);
endinterface

@@ rtl/dasd_ctrl.sv @@
// ----------------------------------------------------------------------------
// dasd_ctrl
// Sequencer: accept, year split, validity check, month walk, result hand-off.
// ----------------------------------------------------------------------------
module dasd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output dasd_pkg::dasd_cmd_t    cmd,
    input  dasd_pkg::dasd_status_t status
);
    import dasd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIVIDE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.invalid ? ST_FINISH : ST_WALK;
            end
            ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    if (status.step_err)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

@@ rtl/dasd_datapath.sv @@
// ----------------------------------------------------------------------------
// dasd_datapath
// Date registers, year/100 split, month length stepping and result register.
// ----------------------------------------------------------------------------
module dasd_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                   clk,
    input  dasd_pkg::dasd_cmd_t    cmd,
    output dasd_pkg::dasd_status_t status,
    input  logic                   operation,
    input  dasd_pkg::day_t         start_day,
    input  dasd_pkg::month_t       start_month,
    input  dasd_pkg::year_t        start_year,
    input  dasd_pkg::incnt_t       day_count,
    output dasd_pkg::day_t         result_day,
    output dasd_pkg::month_t       result_month,
    output dasd_pkg::year_t        result_year,
    output logic                   range_error
);
    import dasd_pkg::*;

    localparam int CNT_W = (COUNT_BITS < INCNT_W) ? COUNT_BITS : INCNT_W;
    localparam int DW    = CNT_W + 2;
    localparam logic DIV_TOP = 1'b1;

    // floor(y / 100) = (y * 5243) >> 19, exact for y below 43690
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;
    localparam logic [PROD_W-1:0] RECIP_100 = PROD_W'(5243);

    typedef logic signed [DW-1:0] dacc_t;

    logic   sub_reg;
    day_t   d0_reg;
    month_t m0_reg;
    year_t  y0_reg;
    dacc_t  d_reg;
    month_t m_reg;
    year_t  y_reg;
    year_t  rem_reg;
    quo_t   q_reg;
    logic   idx_reg;
    logic   err_reg;

    day_t   res_day_reg;
    month_t res_month_reg;
    year_t  res_year_reg;
    logic   res_err_reg;

    logic   leap;
    day_t   ml_cur;
    day_t   ml_prev;
    month_t m_prev;
    dacc_t  ml_cur_x;
    dacc_t  ml_prev_x;
    dacc_t  d_init;
    logic [PROD_W-1:0] quo_prod;
    quo_t   quo_est;
    year_t  cent_prod;
    logic   date_bad;
    logic   roll_up;
    logic   roll_down;

    assign leap     = (y_reg[1:0] == 2'b00) && ((rem_reg != '0) || (q_reg[1:0] == 2'b00));
    assign ml_cur   = month_length(m_reg, leap);
    assign m_prev   = (m_reg == MONTH_JAN) ? MONTH_DEC : m_reg - 4'd1;
    assign ml_prev  = month_length(m_prev, leap);
    assign ml_cur_x  = $signed({{(DW-DAY_W){1'b0}}, ml_cur});
    assign ml_prev_x = $signed({{(DW-DAY_W){1'b0}}, ml_prev});
    assign d_init   = operation
                    ? $signed({{(DW-DAY_W){1'b0}}, start_day})
                      - $signed({2'b00, day_count[CNT_W-1:0]})
                    : $signed({{(DW-DAY_W){1'b0}}, start_day})
                      + $signed({2'b00, day_count[CNT_W-1:0]});
    assign quo_prod  = {{(PROD_W-YEAR_W){1'b0}}, rem_reg} * RECIP_100;
    assign quo_est   = quo_prod[RECIP_SHIFT +: QUO_W];
    assign cent_prod = {{(YEAR_W-QUO_W){1'b0}}, q_reg} * YEAR_CENTURY;
    assign date_bad = (m0_reg < MONTH_JAN) || (m0_reg > MONTH_DEC)
                   || (y0_reg < YEAR_MIN) || (y0_reg > YEAR_MAX)
                   || (d0_reg == '0) || (d0_reg > ml_cur);
    assign roll_up   = !sub_reg && (m_reg == MONTH_DEC);
    assign roll_down =  sub_reg && (m_reg == MONTH_JAN);

    always_comb
    begin
        status.div_last  = !idx_reg;
        status.invalid   = date_bad;
        status.walk_done = sub_reg ? (d_reg >= $signed(DW'(1))) : (d_reg <= ml_cur_x);
        status.step_err  = (roll_up && (y_reg == YEAR_MAX)) || (roll_down && (y_reg == YEAR_MIN));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sub_reg <= operation;
            d0_reg  <= start_day;
            m0_reg  <= start_month;
            y0_reg  <= start_year;
            d_reg   <= d_init;
            m_reg   <= start_month;
            y_reg   <= start_year;
            rem_reg <= start_year;
            q_reg   <= '0;
            idx_reg <= DIV_TOP;
            err_reg <= 1'b0;
        end
        if (cmd.div_step)
        begin
            if (idx_reg)
            begin
                q_reg <= quo_est;
            end
            else
            begin
                rem_reg <= rem_reg - cent_prod;
            end
            idx_reg <= 1'b0;
        end
        if (cmd.check)
        begin
            err_reg <= date_bad;
        end
        if (cmd.walk_step)
        begin
            err_reg <= status.step_err;
            if (sub_reg)
            begin
                m_reg <= m_prev;
                d_reg <= d_reg + ml_prev_x;
                if (roll_down)
                begin
                    y_reg <= y_reg - 14'd1;
                    if (rem_reg == '0)
                    begin
                        rem_reg <= YEAR_REM_TOP;
                        q_reg   <= q_reg - 7'd1;
                    end
                    else
                    begin
                        rem_reg <= rem_reg - 14'd1;
                    end
                end
            end
            else
            begin
                d_reg <= d_reg - ml_cur_x;
                if (roll_up)
                begin
                    m_reg <= MONTH_JAN;
                    y_reg <= y_reg + 14'd1;
                    if (rem_reg == YEAR_REM_TOP)
                    begin
                        rem_reg <= '0;
                        q_reg   <= q_reg + 7'd1;
                    end
                    else
                    begin
                        rem_reg <= rem_reg + 14'd1;
                    end
                end
                else
                begin
                    m_reg <= m_reg + 4'd1;
                end
            end
        end
        if (cmd.out_load)
        begin
            res_err_reg   <= err_reg;
            res_day_reg   <= err_reg ? d0_reg : d_reg[DAY_W-1:0];
            res_month_reg <= err_reg ? m0_reg : m_reg;
            res_year_reg  <= err_reg ? y0_reg : y_reg;
        end
    end

    assign result_day   = res_day_reg;
    assign result_month = res_month_reg;
    assign result_year  = res_year_reg;
    assign range_error  = res_err_reg;

endmodule

@@ rtl/date_add_subtract_days_unit.sv @@
// ----------------------------------------------------------------------------
// date_add_subtract_days_unit
// Gregorian date plus or minus a day count, one month stepped per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req carries operation (0 add, 1 subtract), the start date and day_count;
//   only the low COUNT_BITS bits of day_count are used. rsp returns the
//   resulting date and range_error. Both channels are valid/ready; a
//   transaction moves when valid and ready are high at a clock edge.
//   One request is processed at a time: req.ready is high only when idle.
//   From accept to rsp.valid, a quotient step and a remainder step split the
//   year by 100 for the leap rule, a check step tests the start date, the
//   walk steps one month per cycle (about 2150 months for a count of 65535),
//   the walk state sees the walk end, and the finish state loads the result
//   register once it is free. An invalid start date skips the walk, a year
//   leaving 1..9999 ends it; both return the start date with range_error set.
//   The result register lets a new request be accepted while the previous
//   result waits; a finished walk holds until the register is free.
//   Reset (rst_n, asynchronous, active low) returns to idle and drops
//   rsp.valid; no transaction is in flight afterwards.
// ----------------------------------------------------------------------------
module date_add_subtract_days_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dasd_in_if.sink     req,
    dasd_out_if.source  rsp
);
    import dasd_pkg::*;

    dasd_cmd_t    cmd;
    dasd_status_t status;

    dasd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    dasd_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .status       (status),
        .operation    (req.operation),
        .start_day    (req.start_day),
        .start_month  (req.start_month),
        .start_year   (req.start_year),
        .day_count    (req.day_count),
        .result_day   (rsp.result_day),
        .result_month (rsp.result_month),
        .result_year  (rsp.result_year),
        .range_error  (rsp.range_error)
    );

endmodule

@@ rtl/dasd_checker.sv @@
// ----------------------------------------------------------------------------
// dasd_checker
// Port-level checks on the date add/subtract unit, bound to the top level.
// ----------------------------------------------------------------------------
module dasd_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  dasd_pkg::day_t    result_day,
    input  dasd_pkg::month_t  result_month,
    input  dasd_pkg::year_t   result_year,
    input  logic              range_error
);
    import dasd_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp.valid dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(result_day) && $stable(result_month)
                                    && $stable(result_year) && $stable(range_error))
        else $error("rsp payload changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req.ready high right after a transaction");

    a_result_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !range_error |-> (result_month >= MONTH_JAN) && (result_month <= MONTH_DEC)
                                      && (result_day != '0) && (result_year >= YEAR_MIN)
                                      && (result_year <= YEAR_MAX))
        else $error("result date out of range without range_error");

endmodule

bind date_add_subtract_days_unit dasd_checker u_dasd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_day   (rsp.result_day),
    .result_month (rsp.result_month),
    .result_year  (rsp.result_year),
    .range_error  (rsp.range_error)
);

@@ dv/date_add_subtract_days_unit_tb.sv @@
// ----------------------------------------------------------------------------
// date_add_subtract_days_unit_tb
// Checks each result of the date add/subtract unit against a shifted date
// worked out in the bench. The stimulus is a directed set of calendar edge
// cases and invalid dates, then mostly valid random dates with some noise.
// Both channels idle at random, and the output is held off once for a long
// stretch.
// ----------------------------------------------------------------------------
module date_add_subtract_days_unit_tb;
    import dasd_pkg::*;

    localparam int COUNT_BITS   = 16;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_OFF     = 3000;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic {OP_ADD = 1'b0, OP_SUB = 1'b1} date_op_t;

    typedef struct packed {
        date_op_t op;
        day_t     day;
        month_t   month;
        year_t    year;
        incnt_t   count;
    } date_req_t;

    typedef struct packed {
        day_t   day;
        month_t month;
        year_t  year;
        logic   range_error;
    } date_res_t;

    class date_scoreboard;
        date_res_t due_dates[$];
        int        errors;
        int        requests;
        int        range_errors;
        int        results;

        static function int month_days(int m, int y);
            bit leap;
            leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            if (m == MONTH_FEB)
                return leap ? DAYS_29 : DAYS_28;
            if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
                return DAYS_30;
            return DAYS_31;
        endfunction

        static function date_res_t shift_date(date_req_t r);
            int        d;
            int        m;
            int        y;
            int        cnt;
            bit        bad;
            date_res_t res;
            cnt = int'(r.count) & ((1 << COUNT_BITS) - 1);
            m   = r.month;
            y   = r.year;
            d   = r.day;
            bad = (m < MONTH_JAN || m > MONTH_DEC || y < YEAR_MIN || y > YEAR_MAX ||
                   d < 1 || d > month_days(m, y));
            if (!bad && r.op == OP_ADD)
            begin
                d = d + cnt;
                while (!bad && d > month_days(m, y))
                begin
                    d -= month_days(m, y);
                    m++;
                    if (m > MONTH_DEC)
                    begin
                        m = MONTH_JAN;
                        y++;
                        if (y > YEAR_MAX)
                            bad = 1'b1;
                    end
                end
            end
            else if (!bad)
            begin
                d = d - cnt;
                while (!bad && d < 1)
                begin
                    m--;
                    if (m < MONTH_JAN)
                    begin
                        m = MONTH_DEC;
                        y--;
                        if (y < YEAR_MIN)
                            bad = 1'b1;
                    end
                    if (!bad)
                        d += month_days(m, y);
                end
            end
            if (bad)
            begin
                res.day   = r.day;
                res.month = r.month;
                res.year  = r.year;
            end
            else
            begin
                res.day   = day_t'(d);
                res.month = month_t'(m);
                res.year  = year_t'(y);
            end
            res.range_error = bad;
            return res;
        endfunction

        function void note_request(date_req_t r);
            date_res_t res;
            res = shift_date(r);
            due_dates.push_back(res);
            requests++;
            if (res.range_error)
                range_errors++;
        endfunction

        function void check_result(date_res_t got);
            date_res_t want;
            results++;
            if (due_dates.size() == 0)
            begin
                $error("unexpected result transaction: day %0d month %0d year %0d err %0b",
                       got.day, got.month, got.year, got.range_error);
                errors++;
                return;
            end
            want = due_dates.pop_front();
            if (got.day !== want.day)
            begin
                $error("result_day: expected %0d, actual %0d", want.day, got.day);
                errors++;
            end
            if (got.month !== want.month)
            begin
                $error("result_month: expected %0d, actual %0d", want.month, got.month);
                errors++;
            end
            if (got.year !== want.year)
            begin
                $error("result_year: expected %0d, actual %0d", want.year, got.year);
                errors++;
            end
            if (got.range_error !== want.range_error)
            begin
                $error("range_error: expected %0b, actual %0b", want.range_error,
                       got.range_error);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dasd_in_if  req_if();
    dasd_out_if rsp_if();

    date_add_subtract_days_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    date_scoreboard sb = new();

    int  idle_cycles = 0;
    int  accepted_reqs = 0;
    int  burst_left = 0;
    bit  held_off = 1'b0;

    always #5 clk = ~clk;

    // Output monitor and watchdog
    always @(posedge clk)
    begin
        date_res_t got;
        if (rsp_if.valid && rsp_if.ready)
        begin
            got.day         = rsp_if.result_day;
            got.month       = rsp_if.result_month;
            got.year        = rsp_if.result_year;
            got.range_error = rsp_if.range_error;
            sb.check_result(got);
        end
        if (req_if.valid && req_if.ready)
            accepted_reqs++;
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result receiver: stall pattern, plus one long hold-off
    initial
    begin
        int mode;
        int span;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                if (mode == 0)
                    rsp_if.ready <= 1'b1;
                else if (mode == 1)
                    rsp_if.ready <= 1'($urandom_range(0, 1));
                else
                    rsp_if.ready <= ($urandom_range(0, 3) == 0);
                @(posedge clk);
            end
            if (!held_off && accepted_reqs >= 60)
            begin
                held_off = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
        end
    end

    task automatic send_request(date_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= r.op;
        req_if.start_day   <= r.day;
        req_if.start_month <= r.month;
        req_if.start_year  <= r.year;
        req_if.day_count   <= r.count;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(r);
        burst_left--;
    endtask

    task automatic send_date(date_op_t op, int d, int m, int y, int cnt);
        date_req_t r;
        r.op    = op;
        r.day   = day_t'(d);
        r.month = month_t'(m);
        r.year  = year_t'(y);
        r.count = incnt_t'(cnt);
        send_request(r);
    endtask

    task automatic send_random_date();
        date_req_t r;
        int        pick;
        int        y;
        int        m;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: fields at full width, mostly invalid dates
            r.op    = date_op_t'($urandom_range(0, 1));
            r.day   = day_t'($urandom);
            r.month = month_t'($urandom);
            r.year  = year_t'($urandom);
            r.count = incnt_t'($urandom);
        end
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                y = $urandom_range(YEAR_MIN, YEAR_MAX);
            else if (pick < 8)
                y = $urandom_range(YEAR_MIN, 20);
            else
                y = $urandom_range(9980, YEAR_MAX);
            m       = $urandom_range(MONTH_JAN, MONTH_DEC);
            r.op    = date_op_t'($urandom_range(0, 1));
            r.year  = year_t'(y);
            r.month = month_t'(m);
            r.day   = day_t'($urandom_range(1, date_scoreboard::month_days(m, y)));
            pick    = $urandom_range(0, 19);
            if (pick < 14)
                r.count = incnt_t'($urandom_range(0, 1500));
            else if (pick < 17)
                r.count = incnt_t'($urandom_range(0, 40));
            else
                r.count = incnt_t'($urandom_range(0, 65535));
        end
        send_request(r);
    endtask

    initial
    begin
        req_if.valid       = 1'b0;
        req_if.operation   = OP_ADD;
        req_if.start_day   = '0;
        req_if.start_month = '0;
        req_if.start_year  = '0;
        req_if.day_count   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero count, both directions
        send_date(OP_ADD, 15, 6, 2023, 0);
        send_date(OP_SUB, 31, 12, 9999, 0);
        // full count from the ends of the calendar
        send_date(OP_ADD, 1, 1, 1, 65535);
        send_date(OP_SUB, 31, 12, 9999, 65535);
        // year leaves range
        send_date(OP_ADD, 31, 12, 9999, 1);
        send_date(OP_SUB, 1, 1, 1, 1);
        send_date(OP_ADD, 1, 1, 9900, 65535);
        send_date(OP_SUB, 1, 3, 100, 65535);
        // leap rule: 400-year, 100-year and 4-year cases
        send_date(OP_ADD, 29, 2, 2000, 1);
        send_date(OP_ADD, 28, 2, 2024, 1);
        send_date(OP_SUB, 1, 3, 2100, 1);
        send_date(OP_SUB, 1, 3, 2000, 1);
        send_date(OP_ADD, 28, 2, 1900, 366);
        // invalid start dates
        send_date(OP_ADD, 29, 2, 1900, 5);
        send_date(OP_ADD, 31, 4, 2020, 5);
        send_date(OP_SUB, 0, 5, 2020, 5);
        send_date(OP_ADD, 10, 0, 2020, 5);
        send_date(OP_SUB, 10, 13, 2020, 5);
        send_date(OP_ADD, 31, 15, 2020, 5);
        send_date(OP_ADD, 10, 5, 0, 5);
        send_date(OP_SUB, 10, 5, 10000, 5);
        send_date(OP_ADD, 31, 15, 16383, 65535);
        // month ends
        send_date(OP_ADD, 31, 1, 2023, 28);
        send_date(OP_SUB, 1, 1, 2023, 365);

        repeat (RANDOM_ITEMS)
            send_random_date();

        req_if.valid <= 1'b0;
        while (sb.due_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d flagged out of range), %0d results checked",
                 sb.requests, sb.range_errors, sb.results);
        $display("Long output hold-off applied: %0d, mismatches: %0d", held_off, sb.errors);
        if (sb.errors == 0 && sb.due_dates.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dasd_pkg.sv
rtl/dasd_if.sv
rtl/dasd_ctrl.sv
rtl/dasd_datapath.sv
rtl/date_add_subtract_days_unit.sv
rtl/dasd_checker.sv
dv/date_add_subtract_days_unit_tb.sv
